### rtl/gbg_pkg.sv
// Shared types and constants of the Gaussian blob generator.
// No dependencies; used by gbg_div, gbg_exp and gaussian_blob_generator.
package gbg_pkg;

  // Field widths
  localparam int unsigned ROW_W      = 10;
  localparam int unsigned COL_W      = 10;
  localparam int unsigned LEVEL_W    = 16;
  localparam int unsigned SIDE_CFG_W = 11;

  // Image side register
  localparam logic [SIDE_CFG_W-1:0] SIDE_RESET = 11'd256;
  localparam int unsigned MIN_SIDE = 6;

  // sigma = side / 6 as (side * SIXTH_MUL) >> SIXTH_SHIFT, exact below 32768
  localparam int unsigned SIXTH_MUL   = 10923;
  localparam int unsigned SIXTH_W     = 14;
  localparam int unsigned SIXTH_SHIFT = 16;

  // Fixed point: fractions in Q32, exponent argument is t/16
  localparam int unsigned FRAC_W   = 32;
  localparam int unsigned QUOT_W   = 32;
  localparam int unsigned LOW_BITS = 4;
  localparam int unsigned TAIL_INT = 12;

  // Series and squaring
  localparam int unsigned SERIES_TERMS = 13;
  localparam int unsigned SQUARINGS    = 4;

  // floor(2^32 / k) per series divisor k; k = 1 uses 2^32 - 1, corrected like the rest
  localparam logic [FRAC_W-1:0] RECIP_TAB [SERIES_TERMS+1] = '{
    32'd0,
    32'hFFFF_FFFF,
    32'd2147483648,
    32'd1431655765,
    32'd1073741824,
    32'd858993459,
    32'd715827882,
    32'd613566756,
    32'd536870912,
    32'd477218588,
    32'd429496729,
    32'd390451572,
    32'd357913941,
    32'd330382099
  };

  // Full-scale output, 255.0 in 8.8
  localparam logic [LEVEL_W-1:0] LEVEL_FULL = 16'd65280;

  // Control that travels with each transaction through the pipeline
  typedef struct packed {
    logic valid;
    logic tail;
  } ctl_t;

endpackage

### rtl/gbg_div.sv
// Pipelined restoring divider: one quotient bit per stage, QUOT_W stages.
// Depends on gbg_pkg for widths and the control struct.
module gbg_div #(
  parameter int unsigned DEN_W = 17
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  gbg_pkg::ctl_t                ctl_i,
  input  logic [DEN_W-1:0]             rem_i,
  input  logic [DEN_W-1:0]             den_i,
  input  logic [gbg_pkg::LOW_BITS-1:0] low_i,
  output gbg_pkg::ctl_t                ctl_o,
  output logic [gbg_pkg::QUOT_W-1:0]   quot_o
);

  localparam int unsigned N  = gbg_pkg::QUOT_W;
  localparam int unsigned LW = gbg_pkg::LOW_BITS;

  // Stage sources
  gbg_pkg::ctl_t    ctl_src  [N];
  logic [DEN_W-1:0] rem_src  [N];
  logic [DEN_W-1:0] den_src  [N];
  logic [LW-1:0]    low_src  [N];
  logic [N-1:0]     quot_src [N];

  // Next values
  logic [DEN_W-1:0] rem_d  [N];
  logic [LW-1:0]    low_d  [N];
  logic [N-1:0]     quot_d [N];

  // Stage registers
  gbg_pkg::ctl_t    ctl_q  [N];
  logic [DEN_W-1:0] rem_q  [N];
  logic [DEN_W-1:0] den_q  [N];
  logic [LW-1:0]    low_q  [N];
  logic [N-1:0]     quot_q [N];

  // Chain each stage to the one before it
  for (genvar j = 0; j < N; j++) begin : g_src
    if (j == 0) begin : g_first
      assign ctl_src[j]  = ctl_i;
      assign rem_src[j]  = rem_i;
      assign den_src[j]  = den_i;
      assign low_src[j]  = low_i;
      assign quot_src[j] = '0;
    end else begin : g_next
      assign ctl_src[j]  = ctl_q[j-1];
      assign rem_src[j]  = rem_q[j-1];
      assign den_src[j]  = den_q[j-1];
      assign low_src[j]  = low_q[j-1];
      assign quot_src[j] = quot_q[j-1];
    end
  end

  // Shift in the next dividend bit, subtract the divisor where it fits
  always_comb begin
    logic [DEN_W:0] trial;
    logic           fits;
    trial = '0;
    fits  = 1'b0;
    for (int j = 0; j < N; j++) begin
      trial     = {rem_src[j], low_src[j][LW-1]};
      fits      = (trial >= {1'b0, den_src[j]});
      rem_d[j]  = fits ? DEN_W'(trial - {1'b0, den_src[j]}) : trial[DEN_W-1:0];
      low_d[j]  = {low_src[j][LW-2:0], 1'b0};
      quot_d[j] = {quot_src[j][N-2:0], fits};
    end
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < N; j++) begin
        ctl_q[j] <= '0;
      end
    end else if (en_i) begin
      for (int j = 0; j < N; j++) begin
        ctl_q[j] <= ctl_src[j];
      end
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < N; j++) begin
        rem_q[j]  <= rem_d[j];
        den_q[j]  <= den_src[j];
        low_q[j]  <= low_d[j];
        quot_q[j] <= quot_d[j];
      end
    end
  end

  assign ctl_o  = ctl_q[N-1];
  assign quot_o = quot_q[N-1];

endmodule

### rtl/gbg_exp.sv
// Pipelined exp(-v) in Q32: Horner series, three stages a term, then repeated squaring.
// Depends on gbg_pkg for the series constants, reciprocals and control struct.
module gbg_exp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  gbg_pkg::ctl_t              ctl_i,
  input  logic [gbg_pkg::FRAC_W-1:0] arg_i,
  output gbg_pkg::ctl_t              ctl_o,
  output logic [gbg_pkg::FRAC_W:0]   exp_o
);

  localparam int unsigned T  = gbg_pkg::SERIES_TERMS;
  localparam int unsigned SQ = gbg_pkg::SQUARINGS;
  localparam int unsigned FW = gbg_pkg::FRAC_W;
  localparam int unsigned KW = $clog2(T + 1);
  localparam logic [FW:0] One = {1'b1, {FW{1'b0}}};

  // Term sources
  gbg_pkg::ctl_t ctl_src [T];
  logic [FW-1:0] v_src   [T];
  logic [FW:0]   acc_src [T];

  // Multiply stage
  gbg_pkg::ctl_t m_ctl_q [T];
  logic [FW-1:0] m_v_q   [T];
  logic [FW-1:0] m_x_q   [T];
  logic [FW-1:0] m_x_d   [T];

  // Reciprocal stage
  gbg_pkg::ctl_t r_ctl_q [T];
  logic [FW-1:0] r_v_q   [T];
  logic [FW-1:0] r_x_q   [T];
  logic [FW-1:0] r_q_q   [T];
  logic [FW-1:0] r_q_d   [T];

  // Correction stage
  gbg_pkg::ctl_t c_ctl_q [T];
  logic [FW-1:0] c_v_q   [T];
  logic [FW:0]   c_acc_q [T];
  logic [FW:0]   c_acc_d [T];

  // Squaring stages
  gbg_pkg::ctl_t s_ctl_src [SQ];
  logic [FW:0]   s_e_src   [SQ];
  gbg_pkg::ctl_t s_ctl_q   [SQ];
  logic [FW:0]   s_e_q     [SQ];
  logic [FW:0]   s_e_d     [SQ];

  // Chain the terms, the series starts at 1.0
  for (genvar j = 0; j < T; j++) begin : g_term_src
    if (j == 0) begin : g_first
      assign ctl_src[j] = ctl_i;
      assign v_src[j]   = arg_i;
      assign acc_src[j] = One;
    end else begin : g_next
      assign ctl_src[j] = c_ctl_q[j-1];
      assign v_src[j]   = c_v_q[j-1];
      assign acc_src[j] = c_acc_q[j-1];
    end
  end

  for (genvar i = 0; i < SQ; i++) begin : g_sq_src
    if (i == 0) begin : g_first
      assign s_ctl_src[i] = c_ctl_q[T-1];
      assign s_e_src[i]   = c_acc_q[T-1];
    end else begin : g_next
      assign s_ctl_src[i] = s_ctl_q[i-1];
      assign s_e_src[i]   = s_e_q[i-1];
    end
  end

  // Term math: x = v*acc, q = floor(x/k) by reciprocal with one correction, acc = 1 - q
  always_comb begin
    logic [2*FW-1:0] prod_m;
    logic [2*FW-1:0] prod_r;
    logic [FW+KW-1:0] back;
    logic [FW+KW-1:0] rem;
    logic [FW-1:0]    term;
    logic             bump;
    prod_m = '0;
    prod_r = '0;
    back   = '0;
    rem    = '0;
    term   = '0;
    bump   = 1'b0;
    for (int j = 0; j < T; j++) begin
      prod_m   = (2*FW)'(v_src[j]) * (2*FW)'(acc_src[j][FW-1:0]);
      m_x_d[j] = acc_src[j][FW] ? v_src[j] : prod_m[2*FW-1:FW];

      prod_r   = (2*FW)'(m_x_q[j]) * (2*FW)'(gbg_pkg::RECIP_TAB[T-j]);
      r_q_d[j] = prod_r[2*FW-1:FW];

      back       = (FW+KW)'(r_q_q[j]) * (FW+KW)'(T - j);
      rem        = (FW+KW)'(r_x_q[j]) - back;
      bump       = (rem >= (FW+KW)'(T - j));
      term       = r_q_q[j] + FW'(bump);
      c_acc_d[j] = One - (FW+1)'(term);
    end
  end

  // Square, holding 1.0 as 1.0
  always_comb begin
    logic [2*FW-1:0] sqr;
    sqr = '0;
    for (int i = 0; i < SQ; i++) begin
      sqr      = (2*FW)'(s_e_src[i][FW-1:0]) * (2*FW)'(s_e_src[i][FW-1:0]);
      s_e_d[i] = s_e_src[i][FW] ? One : {1'b0, sqr[2*FW-1:FW]};
    end
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < T; j++) begin
        m_ctl_q[j] <= '0;
        r_ctl_q[j] <= '0;
        c_ctl_q[j] <= '0;
      end
      for (int i = 0; i < SQ; i++) begin
        s_ctl_q[i] <= '0;
      end
    end else if (en_i) begin
      for (int j = 0; j < T; j++) begin
        m_ctl_q[j] <= ctl_src[j];
        r_ctl_q[j] <= m_ctl_q[j];
        c_ctl_q[j] <= r_ctl_q[j];
      end
      for (int i = 0; i < SQ; i++) begin
        s_ctl_q[i] <= s_ctl_src[i];
      end
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < T; j++) begin
        m_v_q[j]   <= v_src[j];
        m_x_q[j]   <= m_x_d[j];
        r_v_q[j]   <= m_v_q[j];
        r_x_q[j]   <= m_x_q[j];
        r_q_q[j]   <= r_q_d[j];
        c_v_q[j]   <= r_v_q[j];
        c_acc_q[j] <= c_acc_d[j];
      end
      for (int i = 0; i < SQ; i++) begin
        s_e_q[i] <= s_e_d[i];
      end
    end
  end

  assign ctl_o = s_ctl_q[SQ-1];
  assign exp_o = s_e_q[SQ-1];

endmodule

### rtl/gaussian_blob_generator.sv
// Each transaction passes through 81 stages, from the input stage to the output register.
// Throughput: one pixel per cycle while not stalled; depth is set by the 32-step divider
// forming t/16 and the 13 series terms at three stages each, plus four squaring stages.
// A stalled result holds the whole pipeline in place; nothing is lost or repeated.
// Reset clears all valid bits and sets the image side to 256; payload is not reset.
// Depends on gbg_pkg, gbg_div and gbg_exp.
module gaussian_blob_generator #(
  parameter int unsigned MAX_SIDE = 1024
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [gbg_pkg::SIDE_CFG_W-1:0]   cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [gbg_pkg::ROW_W-1:0]        row_i,
  input  logic [gbg_pkg::COL_W-1:0]        col_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [gbg_pkg::LEVEL_W-1:0]      level_o
);

  localparam int unsigned CfgW   = gbg_pkg::SIDE_CFG_W;
  localparam int unsigned SideW  = $clog2(MAX_SIDE + 1);
  localparam int unsigned CmpW   = (SideW > CfgW) ? SideW : CfgW;
  localparam int unsigned CoordW = (gbg_pkg::ROW_W > gbg_pkg::COL_W) ?
                                   gbg_pkg::ROW_W : gbg_pkg::COL_W;
  localparam int unsigned MagW   = ((SideW - 1) > CoordW) ? (SideW - 1) : CoordW;
  localparam int unsigned SigW   = SideW - 2;
  localparam int unsigned D2W    = 2 * MagW + 1;
  localparam int unsigned DenW   = 2 * SigW + 1;
  localparam int unsigned TailW  = (D2W > DenW + 4) ? D2W : DenW + 4;
  localparam int unsigned SixW   = SideW + gbg_pkg::SIXTH_W;
  localparam int unsigned FW     = gbg_pkg::FRAC_W;
  localparam int unsigned LW     = gbg_pkg::LEVEL_W;
  localparam int unsigned PW     = FW + 1 + LW;
  localparam int unsigned LowW   = gbg_pkg::LOW_BITS;

  logic en;

  // Configuration and input stage
  logic [CfgW-1:0]             side_q;
  logic [CmpW-1:0]             side_ext;
  logic [SideW-1:0]            side_clamp;
  logic                        a_valid_q;
  logic [gbg_pkg::ROW_W-1:0]   a_row_q;
  logic [gbg_pkg::COL_W-1:0]   a_col_q;
  logic [SideW-1:0]            a_side_q;

  // Offset stage
  logic [SideW-2:0]            half;
  logic signed [MagW:0]        dx_s;
  logic signed [MagW:0]        dy_s;
  logic [SixW-1:0]             sig_prod;
  logic                        b_valid_q;
  logic [MagW-1:0]             b_dx_q;
  logic [MagW-1:0]             b_dy_q;
  logic [SigW-1:0]             b_sig_q;

  // Square stage
  logic                        c_valid_q;
  logic [2*MagW-1:0]           c_dx2_q;
  logic [2*MagW-1:0]           c_dy2_q;
  logic [2*SigW-1:0]           c_sig2_q;

  // Sum stage
  logic                        d_valid_q;
  logic [D2W-1:0]              d_d2_q;
  logic [DenW-1:0]             d_den_q;

  // Tail check and divider setup
  logic [TailW-1:0]            tail_bound;
  gbg_pkg::ctl_t               e_ctl_q;
  logic [DenW-1:0]             e_rem_q;
  logic [DenW-1:0]             e_den_q;
  logic [LowW-1:0]             e_low_q;

  // Divider and exponential
  gbg_pkg::ctl_t               div_ctl;
  logic [gbg_pkg::QUOT_W-1:0]  div_quot;
  gbg_pkg::ctl_t               exp_ctl;
  logic [FW:0]                 exp_val;

  // Output stage
  logic [PW-1:0]               lvl_sum;
  logic [PW-FW-1:0]            lvl_round;
  logic [LW-1:0]               level_d;
  logic                        o_valid_q;
  logic [LW-1:0]               o_level_q;

  // Hold everything while a result waits
  assign en         = !(o_valid_q && out_stall_i);
  assign in_stall_o = o_valid_q && out_stall_i;

  // Image side register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= gbg_pkg::SIDE_RESET;
    end else if (cfg_we_i) begin
      side_q <= cfg_wdata_i;
    end
  end

  // Clamp the side into its working range
  always_comb begin
    side_ext = CmpW'(side_q);
    priority if (side_ext < CmpW'(gbg_pkg::MIN_SIDE)) begin
      side_clamp = SideW'(gbg_pkg::MIN_SIDE);
    end else if (side_ext > CmpW'(MAX_SIDE)) begin
      side_clamp = SideW'(MAX_SIDE);
    end else begin
      side_clamp = SideW'(side_ext);
    end
  end

  // Offsets from center and sigma
  assign half     = a_side_q[SideW-1:1];
  assign dx_s     = signed'({1'b0, MagW'(a_row_q)}) - signed'({1'b0, MagW'(half)});
  assign dy_s     = signed'({1'b0, MagW'(a_col_q)}) - signed'({1'b0, MagW'(half)});
  assign sig_prod = SixW'(a_side_q) * SixW'(gbg_pkg::SIXTH_MUL);

  // Far tail when d2 >= 12 * den
  assign tail_bound = TailW'(d_den_q) * TailW'(gbg_pkg::TAIL_INT);

  // Front-end valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
      e_ctl_q   <= '0;
    end else if (en) begin
      a_valid_q     <= in_valid_i;
      b_valid_q     <= a_valid_q;
      c_valid_q     <= b_valid_q;
      d_valid_q     <= c_valid_q;
      e_ctl_q.valid <= d_valid_q;
      e_ctl_q.tail  <= (TailW'(d_d2_q) >= tail_bound);
    end
  end

  // Front-end payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      a_row_q  <= row_i;
      a_col_q  <= col_i;
      a_side_q <= side_clamp;
      b_dx_q   <= dx_s[MagW] ? MagW'(-dx_s) : MagW'(dx_s);
      b_dy_q   <= dy_s[MagW] ? MagW'(-dy_s) : MagW'(dy_s);
      b_sig_q  <= sig_prod[gbg_pkg::SIXTH_SHIFT +: SigW];
      c_dx2_q  <= (2*MagW)'(b_dx_q) * (2*MagW)'(b_dx_q);
      c_dy2_q  <= (2*MagW)'(b_dy_q) * (2*MagW)'(b_dy_q);
      c_sig2_q <= (2*SigW)'(b_sig_q) * (2*SigW)'(b_sig_q);
      d_d2_q   <= D2W'(c_dx2_q) + D2W'(c_dy2_q);
      d_den_q  <= {c_sig2_q, 1'b0};
      e_rem_q  <= DenW'(d_d2_q >> LowW);
      e_den_q  <= d_den_q;
      e_low_q  <= d_d2_q[LowW-1:0];
    end
  end

  // t / 16 in Q32
  gbg_div #(
    .DEN_W (DenW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .ctl_i  (e_ctl_q),
    .rem_i  (e_rem_q),
    .den_i  (e_den_q),
    .low_i  (e_low_q),
    .ctl_o  (div_ctl),
    .quot_o (div_quot)
  );

  // exp(-t) in Q32
  gbg_exp u_exp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .ctl_i  (div_ctl),
    .arg_i  (div_quot),
    .ctl_o  (exp_ctl),
    .exp_o  (exp_val)
  );

  // Scale to 8.8 with rounding, drop the far tail
  assign lvl_sum   = PW'(exp_val) * PW'(gbg_pkg::LEVEL_FULL) + (PW'(1) << (FW - 1));
  assign lvl_round = lvl_sum[PW-1:FW];

  always_comb begin
    priority if (exp_ctl.tail) begin
      level_d = '0;
    end else if (lvl_round > (PW-FW)'(gbg_pkg::LEVEL_FULL)) begin
      level_d = gbg_pkg::LEVEL_FULL;
    end else begin
      level_d = lvl_round[LW-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else if (en) begin
      o_valid_q <= exp_ctl.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      o_level_q <= level_d;
    end
  end

  assign out_valid_o = o_valid_q;
  assign level_o     = o_level_q;

endmodule
